[src/pmj_pkg.sv]
package pmj_pkg;

  // Largest patch side the position counters support
  localparam int MAX_PATCH_WIDTH = 64;
  localparam int CNT_W = $clog2(MAX_PATCH_WIDTH);

  // Register field widths
  localparam int PW_W = 7;
  localparam int DIFF_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATCH_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_TOL = 2'd1;

  // Reset values
  localparam logic [PW_W-1:0] RESET_PATCH_WIDTH = 7'd16;
  localparam logic [DIFF_W-1:0] RESET_DEPTH_TOL = 16'd100;
  localparam logic [PW_W-1:0] MIN_PATCH_WIDTH = 7'd2;
  localparam logic [PW_W-1:0] TOP_PATCH_WIDTH = PW_W'(MAX_PATCH_WIDTH);

  // Jump counter saturation
  localparam int JUMP_W = 7;
  localparam logic [JUMP_W-1:0] JUMP_MAX = 7'd127;

  // Position of one point on the middle cross of the patch
  typedef struct packed {
    logic row_first;  // column 0 of the middle row
    logic row_test;   // columns 1.. of the middle row
    logic row_c1;     // column 1
    logic col_first;  // row 0 of the middle column
    logic col_test;   // tested rows of the middle column
    logic col_r1;     // row 1
    logic last;       // last point of the patch
  } pos_flags_t;

endpackage

[src/patch_moments_with_jump_count_core.sv]
// Patch moment accumulator. Points of one square patch (side patch_width,
// clamped to 2..64) stream in row-major order, one beat per clock; the block
// sums x, y, z, the count of points with z > 0 and all six second moments,
// and counts depth jumps along the middle row and middle column. One result
// beat is presented per patch once its last point has passed through an input
// register, a product register (six multipliers of at most 16x17 bits) and
// the accumulator/result register. Input stalls only when a patch's last
// point meets a result still waiting to be taken. Writing patch_width drops
// the running patch; the depth tolerance takes effect at once.
module patch_moments_with_jump_count_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [pmj_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pmj_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [15:0] z,
  output logic out_valid,
  input  logic out_stall,
  output logic [12:0] valid_count,
  output logic signed [27:0] sum_x,
  output logic signed [27:0] sum_y,
  output logic [27:0] sum_z,
  output logic [42:0] sum_xx,
  output logic [42:0] sum_yy,
  output logic [43:0] sum_zz,
  output logic signed [43:0] sum_xy,
  output logic signed [43:0] sum_xz,
  output logic signed [43:0] sum_yz,
  output logic [6:0] jump_count
);

  logic [pmj_pkg::PW_W-1:0] width;
  logic [pmj_pkg::DIFF_W-1:0] depth_tol;
  logic [pmj_pkg::PW_W-1:0] pw_raw;
  logic [pmj_pkg::PW_W-1:0] width_next;
  logic clear;
  logic in_ready;

  logic s1_valid;
  logic s1_ready;
  logic signed [15:0] s1_x;
  logic signed [15:0] s1_y;
  logic [15:0] s1_z;
  pmj_pkg::pos_flags_t s1_flags;

  logic s2_valid;
  logic s2_ready;
  logic signed [15:0] s2_x;
  logic signed [15:0] s2_y;
  logic [15:0] s2_z;
  pmj_pkg::pos_flags_t s2_flags;
  logic [30:0] p_xx;
  logic [30:0] p_yy;
  logic [31:0] p_zz;
  logic signed [31:0] p_xy;
  logic signed [32:0] p_xz;
  logic signed [32:0] p_yz;

  assign in_stall = !in_ready;
  assign clear = cfg_write && (cfg_index == pmj_pkg::CFG_PATCH_WIDTH);

  // Clamp the patch width into the supported range
  always_comb begin
    pw_raw = cfg_data[pmj_pkg::PW_W-1:0];
    if (pw_raw < pmj_pkg::MIN_PATCH_WIDTH) begin
      width_next = pmj_pkg::MIN_PATCH_WIDTH;
    end else if (pw_raw > pmj_pkg::TOP_PATCH_WIDTH) begin
      width_next = pmj_pkg::TOP_PATCH_WIDTH;
    end else begin
      width_next = pw_raw;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width <= pmj_pkg::RESET_PATCH_WIDTH;
      depth_tol <= pmj_pkg::RESET_DEPTH_TOL;
    end else if (cfg_write) begin
      case (cfg_index)
        pmj_pkg::CFG_PATCH_WIDTH: width <= width_next;
        pmj_pkg::CFG_DEPTH_TOL: depth_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  pmj_seq u_seq (
    .clk(clk),
    .rst(rst),
    .clear(clear),
    .width(width),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .x(x),
    .y(y),
    .z(z),
    .s1_valid(s1_valid),
    .s1_ready(s1_ready),
    .s1_x(s1_x),
    .s1_y(s1_y),
    .s1_z(s1_z),
    .s1_flags(s1_flags)
  );

  pmj_mul u_mul (
    .clk(clk),
    .rst(rst),
    .clear(clear),
    .s1_valid(s1_valid),
    .s1_ready(s1_ready),
    .s1_x(s1_x),
    .s1_y(s1_y),
    .s1_z(s1_z),
    .s1_flags(s1_flags),
    .s2_valid(s2_valid),
    .s2_ready(s2_ready),
    .s2_x(s2_x),
    .s2_y(s2_y),
    .s2_z(s2_z),
    .s2_flags(s2_flags),
    .p_xx(p_xx),
    .p_yy(p_yy),
    .p_zz(p_zz),
    .p_xy(p_xy),
    .p_xz(p_xz),
    .p_yz(p_yz)
  );

  pmj_acc u_acc (
    .clk(clk),
    .rst(rst),
    .clear(clear),
    .depth_tol(depth_tol),
    .s2_valid(s2_valid),
    .s2_ready(s2_ready),
    .s2_x(s2_x),
    .s2_y(s2_y),
    .s2_z(s2_z),
    .s2_flags(s2_flags),
    .p_xx(p_xx),
    .p_yy(p_yy),
    .p_zz(p_zz),
    .p_xy(p_xy),
    .p_xz(p_xz),
    .p_yz(p_yz),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .valid_count(valid_count),
    .sum_x(sum_x),
    .sum_y(sum_y),
    .sum_z(sum_z),
    .sum_xx(sum_xx),
    .sum_yy(sum_yy),
    .sum_zz(sum_zz),
    .sum_xy(sum_xy),
    .sum_xz(sum_xz),
    .sum_yz(sum_yz),
    .jump_count(jump_count)
  );

endmodule

[src/pmj_seq.sv]
module pmj_seq (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic [pmj_pkg::PW_W-1:0] width,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] x,
  input  logic signed [15:0] y,
  input  logic [15:0] z,
  output logic s1_valid,
  input  logic s1_ready,
  output logic signed [15:0] s1_x,
  output logic signed [15:0] s1_y,
  output logic [15:0] s1_z,
  output pmj_pkg::pos_flags_t s1_flags
);

  logic [pmj_pkg::CNT_W-1:0] row;
  logic [pmj_pkg::CNT_W-1:0] col;
  logic [pmj_pkg::CNT_W-1:0] half;
  logic [pmj_pkg::CNT_W-1:0] wm1;
  logic row_end;
  logic col_end;
  logic accept;
  pmj_pkg::pos_flags_t flags;

  assign in_ready = !s1_valid || s1_ready;
  assign accept = in_valid && in_ready;
  assign half = pmj_pkg::CNT_W'(width >> 1);
  assign wm1 = pmj_pkg::CNT_W'(width - 7'd1);
  assign row_end = (row == wm1);
  assign col_end = (col == wm1);

  // Classify the point against the middle row and middle column
  always_comb begin
    flags.row_first = (row == half) && (col == '0);
    flags.row_test = (row == half) && (col != '0);
    flags.row_c1 = (col == pmj_pkg::CNT_W'(1));
    flags.col_first = (col == half) && (row == '0);
    // even widths skip the last row of the middle column
    flags.col_test = (col == half) && (row != '0) && (width[0] || !row_end);
    flags.col_r1 = (row == pmj_pkg::CNT_W'(1));
    flags.last = row_end && col_end;
  end

  // Advance the raster position on each accepted beat
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x <= x;
      s1_y <= y;
      s1_z <= z;
      s1_flags <= flags;
    end
  end

endmodule

[src/pmj_mul.sv]
module pmj_mul (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic s1_valid,
  output logic s1_ready,
  input  logic signed [15:0] s1_x,
  input  logic signed [15:0] s1_y,
  input  logic [15:0] s1_z,
  input  pmj_pkg::pos_flags_t s1_flags,
  output logic s2_valid,
  input  logic s2_ready,
  output logic signed [15:0] s2_x,
  output logic signed [15:0] s2_y,
  output logic [15:0] s2_z,
  output pmj_pkg::pos_flags_t s2_flags,
  output logic [30:0] p_xx,
  output logic [30:0] p_yy,
  output logic [31:0] p_zz,
  output logic signed [31:0] p_xy,
  output logic signed [32:0] p_xz,
  output logic signed [32:0] p_yz
);

  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [16:0] zs;
  logic signed [32:0] m_xz;
  logic signed [32:0] m_yz;
  logic signed [31:0] m_xy;
  logic [31:0] m_zz;

  assign s1_ready = !s2_valid || s2_ready;

  // Second-moment products of one point
  assign zs = {1'b0, s1_z};
  assign sq_x = s1_x * s1_x;
  assign sq_y = s1_y * s1_y;
  assign m_xy = s1_x * s1_y;
  assign m_xz = s1_x * zs;
  assign m_yz = s1_y * zs;
  assign m_zz = s1_z * s1_z;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      s2_valid <= 1'b0;
    end else if (s1_ready) begin
      s2_valid <= s1_valid;
    end
  end

  // Product register
  always_ff @(posedge clk) begin
    if (s1_valid && s1_ready) begin
      s2_x <= s1_x;
      s2_y <= s1_y;
      s2_z <= s1_z;
      s2_flags <= s1_flags;
      p_xx <= sq_x[30:0];
      p_yy <= sq_y[30:0];
      p_zz <= m_zz;
      p_xy <= m_xy;
      p_xz <= m_xz;
      p_yz <= m_yz;
    end
  end

endmodule

[src/pmj_acc.sv]
module pmj_acc (
  input  logic clk,
  input  logic rst,
  input  logic clear,
  input  logic [pmj_pkg::DIFF_W-1:0] depth_tol,
  input  logic s2_valid,
  output logic s2_ready,
  input  logic signed [15:0] s2_x,
  input  logic signed [15:0] s2_y,
  input  logic [15:0] s2_z,
  input  pmj_pkg::pos_flags_t s2_flags,
  input  logic [30:0] p_xx,
  input  logic [30:0] p_yy,
  input  logic [31:0] p_zz,
  input  logic signed [31:0] p_xy,
  input  logic signed [32:0] p_xz,
  input  logic signed [32:0] p_yz,
  output logic out_valid,
  input  logic out_stall,
  output logic [12:0] valid_count,
  output logic signed [27:0] sum_x,
  output logic signed [27:0] sum_y,
  output logic [27:0] sum_z,
  output logic [42:0] sum_xx,
  output logic [42:0] sum_yy,
  output logic [43:0] sum_zz,
  output logic signed [43:0] sum_xy,
  output logic signed [43:0] sum_xz,
  output logic signed [43:0] sum_yz,
  output logic [pmj_pkg::JUMP_W-1:0] jump_count
);

  logic [12:0] cnt;
  logic [27:0] ax;
  logic [27:0] ay;
  logic [27:0] az;
  logic [42:0] axx;
  logic [42:0] ayy;
  logic [43:0] azz;
  logic [43:0] axy;
  logic [43:0] axz;
  logic [43:0] ayz;
  logic [pmj_pkg::JUMP_W-1:0] jump;
  logic [15:0] row_ref;
  logic [15:0] col_ref;

  logic [12:0] cnt_next;
  logic [27:0] ax_next;
  logic [27:0] ay_next;
  logic [27:0] az_next;
  logic [42:0] axx_next;
  logic [42:0] ayy_next;
  logic [43:0] azz_next;
  logic [43:0] axy_next;
  logic [43:0] axz_next;
  logic [43:0] ayz_next;
  logic [pmj_pkg::JUMP_W-1:0] jump_next;
  logic [15:0] row_ref_next;
  logic [15:0] col_ref_next;

  logic [15:0] row_base;
  logic [15:0] col_base;
  logic [15:0] row_diff;
  logic [15:0] col_diff;
  logic row_hit;
  logic col_hit;
  logic row_cont;
  logic col_cont;
  logic row_jump;
  logic col_jump;
  logic [pmj_pkg::JUMP_W:0] jump_sum;
  logic fire;

  // Only the last point of a patch needs room in the result register
  assign s2_ready = !s2_flags.last || !out_valid || !out_stall;
  assign fire = s2_valid && s2_ready;

  // Accumulate sums and moments
  always_comb begin
    cnt_next = cnt + {12'd0, (s2_z != 16'd0)};
    ax_next = ax + {{12{s2_x[15]}}, s2_x};
    ay_next = ay + {{12{s2_y[15]}}, s2_y};
    az_next = az + {12'd0, s2_z};
    axx_next = axx + {12'd0, p_xx};
    ayy_next = ayy + {12'd0, p_yy};
    azz_next = azz + {12'd0, p_zz};
    axy_next = axy + {{12{p_xy[31]}}, p_xy};
    axz_next = axz + {{11{p_xz[32]}}, p_xz};
    ayz_next = ayz + {{11{p_yz[32]}}, p_yz};
  end

  // Track depth references and count jumps on the middle cross
  always_comb begin
    row_base = (s2_flags.row_c1 && (s2_z > row_ref)) ? s2_z : row_ref;
    row_diff = (s2_z > row_base) ? s2_z - row_base : row_base - s2_z;
    row_cont = row_diff < depth_tol;
    row_hit = s2_flags.row_test && (s2_z != 16'd0);
    row_jump = row_hit && !row_cont;
    if (s2_flags.row_first || (row_hit && row_cont)) begin
      row_ref_next = s2_z;
    end else if (s2_flags.row_test) begin
      row_ref_next = row_base;
    end else begin
      row_ref_next = row_ref;
    end

    col_base = (s2_flags.col_r1 && (s2_z > col_ref)) ? s2_z : col_ref;
    col_diff = (s2_z > col_base) ? s2_z - col_base : col_base - s2_z;
    col_cont = col_diff < depth_tol;
    col_hit = s2_flags.col_test && (s2_z != 16'd0);
    col_jump = col_hit && !col_cont;
    if (s2_flags.col_first || (col_hit && col_cont)) begin
      col_ref_next = s2_z;
    end else if (s2_flags.col_test) begin
      col_ref_next = col_base;
    end else begin
      col_ref_next = col_ref;
    end

    // saturate the jump count
    jump_sum = {1'b0, jump} + {{pmj_pkg::JUMP_W{1'b0}}, row_jump}
             + {{pmj_pkg::JUMP_W{1'b0}}, col_jump};
    if (jump_sum > {1'b0, pmj_pkg::JUMP_MAX}) begin
      jump_next = pmj_pkg::JUMP_MAX;
    end else begin
      jump_next = jump_sum[pmj_pkg::JUMP_W-1:0];
    end
  end

  // Accumulator registers, cleared after each patch
  always_ff @(posedge clk) begin
    if (rst || clear || (fire && s2_flags.last)) begin
      cnt <= '0;
      ax <= '0;
      ay <= '0;
      az <= '0;
      axx <= '0;
      ayy <= '0;
      azz <= '0;
      axy <= '0;
      axz <= '0;
      ayz <= '0;
      jump <= '0;
      row_ref <= '0;
      col_ref <= '0;
    end else if (fire) begin
      cnt <= cnt_next;
      ax <= ax_next;
      ay <= ay_next;
      az <= az_next;
      axx <= axx_next;
      ayy <= ayy_next;
      azz <= azz_next;
      axy <= axy_next;
      axz <= axz_next;
      ayz <= ayz_next;
      jump <= jump_next;
      row_ref <= row_ref_next;
      col_ref <= col_ref_next;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_valid <= 1'b0;
    end else if (fire && s2_flags.last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s2_flags.last) begin
      valid_count <= cnt_next;
      sum_x <= ax_next;
      sum_y <= ay_next;
      sum_z <= az_next;
      sum_xx <= axx_next;
      sum_yy <= ayy_next;
      sum_zz <= azz_next;
      sum_xy <= axy_next;
      sum_xz <= axz_next;
      sum_yz <= ayz_next;
      jump_count <= jump_next;
    end
  end

endmodule
